### src/ssdp_pkg.sv
package ssdp_pkg;

  // fixed field widths
  localparam int unsigned CMD_WIDTH        = 2;
  localparam int unsigned ELEM_INDEX_WIDTH = 16;
  localparam int unsigned VALUE_WIDTH      = 32;
  localparam int unsigned ACC_WIDTH        = 64;
  localparam int unsigned VL_WIDTH         = 17;
  localparam int unsigned STATUS_WIDTH     = 2;

  // command codes
  localparam logic [CMD_WIDTH-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_COMPUTE = 2'd2;

  // status bit positions
  localparam int unsigned STATUS_SAT_BIT = 0;
  localparam int unsigned STATUS_ERR_BIT = 1;

  localparam logic [VL_WIDTH-1:0] VL_RESET = 17'h10000;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

endpackage

### src/sparse_sparse_dot_product.sv
// sparse_sparse_dot_product: dot product of two sparse vectors by merge intersection
//
// input channel (in_valid / in_stall): one word is a command with an index
// and a Q16.16 value. command 0 appends the pair to list A, 1 to list B,
// 2 runs the merge and emits one result, 3 is taken and ignored. a pair with
// an index at or above vector_length, or sent to a full list, is dropped and
// flags a load error reported with the next result.
// output channel (out_valid / out_stall): one word per compute command, the
// saturated Q32.32 dot product and a status (bit 0 saturated, bit 1 load
// error). both lists and the error flag are emptied when the result is made.
// config: cfg_write / cfg_data sets vector_length (reset value 65536).
// throughput: loads and ignored commands are taken one per cycle while the
// block is idle. a compute runs the merge steps (at most a_count + b_count
// - 1), one step per cycle, set by the single read port of each list memory.
// the input is stalled during the merge.
// stall: a finished result sits in the output register; a load may still
// enter, while a compute that finishes with the output still held waits
// with in_stall high until the word is taken.
// reset: synchronous, empties both lists, clears the error flag and the
// output register. list memories are not cleared.
module sparse_sparse_dot_product #(
  parameter int unsigned MAX_NONZEROS = 1024,
  parameter int unsigned INDEX_BITS   = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_write,
  input  logic [ssdp_pkg::VL_WIDTH-1:0]            cfg_data,
  // input words
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [ssdp_pkg::CMD_WIDTH-1:0]           command,
  input  logic [ssdp_pkg::ELEM_INDEX_WIDTH-1:0]    elem_index,
  input  logic signed [ssdp_pkg::VALUE_WIDTH-1:0]  elem_value,
  // result words
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ssdp_pkg::ACC_WIDTH-1:0]    dot_product,
  output logic [ssdp_pkg::STATUS_WIDTH-1:0]        status
);
  import ssdp_pkg::*;

  // stored index width: only the low INDEX_BITS bits of elem_index count
  localparam int unsigned IW = (INDEX_BITS < ELEM_INDEX_WIDTH) ? INDEX_BITS
                                                               : ELEM_INDEX_WIDTH;
  localparam int unsigned AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int unsigned CW = $clog2(MAX_NONZEROS + 1);
  localparam int unsigned EW = IW + VALUE_WIDTH;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_NONZEROS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_DONE
  } state_t;

  state_t state;

  // list memories, one entry holds {index, value}
  logic [EW-1:0] mem_a [MAX_NONZEROS];
  logic [EW-1:0] mem_b [MAX_NONZEROS];
  logic [EW-1:0] rd_a;
  logic [EW-1:0] rd_b;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  logic [VL_WIDTH-1:0] vector_length;
  logic [CW-1:0]       a_count;
  logic [CW-1:0]       b_count;
  logic                load_error;
  logic [CW-1:0]       ptr_a;
  logic [CW-1:0]       ptr_b;
  logic [CW-1:0]       ptr_a_next;
  logic [CW-1:0]       ptr_b_next;

  logic signed [ACC_WIDTH-1:0] mult;
  logic signed [ACC_WIDTH-1:0] prod;
  logic                        prod_valid;
  logic signed [ACC_WIDTH-1:0] acc;
  logic                        sat;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic                        sat_next;
  logic signed [ACC_WIDTH-1:0] sum;
  logic                        ovf;

  logic          in_take;
  logic          start;
  logic          emit;
  logic [IW-1:0] load_index;
  logic          load_ok;
  logic          wr_a;
  logic          wr_b;
  logic          out_free;

  logic                          cont;
  logic [IW-1:0]                 a_idx;
  logic [IW-1:0]                 b_idx;
  logic signed [VALUE_WIDTH-1:0] a_val;
  logic signed [VALUE_WIDTH-1:0] b_val;
  logic                          adv_a;
  logic                          adv_b;
  logic                          match;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && (command == CMD_COMPUTE);
  assign out_free = !out_valid || !out_stall;

  // load path: range check against vector_length
  assign load_index = elem_index[IW-1:0];
  assign load_ok    = ({{(VL_WIDTH-IW){1'b0}}, load_index} < vector_length);
  assign wr_a = in_take && (command == CMD_LOAD_A) && load_ok && (a_count < MAX_COUNT);
  assign wr_b = in_take && (command == CMD_LOAD_B) && load_ok && (b_count < MAX_COUNT);

  // merge step on the entries read last cycle
  assign cont  = (ptr_a < a_count) && (ptr_b < b_count);
  assign a_idx = rd_a[EW-1:VALUE_WIDTH];
  assign b_idx = rd_b[EW-1:VALUE_WIDTH];
  assign a_val = rd_a[VALUE_WIDTH-1:0];
  assign b_val = rd_b[VALUE_WIDTH-1:0];
  assign adv_a = (state == S_MERGE) && cont && (a_idx <= b_idx);
  assign adv_b = (state == S_MERGE) && cont && (a_idx >= b_idx);
  assign match = adv_a && adv_b;

  // result word leaves the merge once the output register is free
  assign emit = out_free && (((state == S_MERGE) && !cont) || (state == S_DONE));

  assign ptr_a_next = ptr_a + CW'(adv_a);
  assign ptr_b_next = ptr_b + CW'(adv_b);

  // full signed product of the two Q16.16 values
  assign mult = ACC_WIDTH'(a_val) * ACC_WIDTH'(b_val);

  // read ahead at the next pointer so each step sees its entry
  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    if (state == S_MERGE && ptr_a_next < MAX_COUNT) begin
      rd_addr_a = ptr_a_next[AW-1:0];
    end
    if (state == S_MERGE && ptr_b_next < MAX_COUNT) begin
      rd_addr_b = ptr_b_next[AW-1:0];
    end
  end

  // saturating accumulate of the registered product, cleared on a compute
  always_comb begin
    sum      = acc + prod;
    ovf      = (acc[ACC_WIDTH-1] == prod[ACC_WIDTH-1]) &&
               (sum[ACC_WIDTH-1] != acc[ACC_WIDTH-1]);
    acc_next = acc;
    sat_next = sat;
    if (start) begin
      acc_next = '0;
      sat_next = 1'b0;
    end else if (prod_valid) begin
      if (ovf) begin
        acc_next = acc[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
        sat_next = 1'b1;
      end else begin
        acc_next = sum;
      end
    end
  end

  // memories: writes only while idle, reads only matter during the merge,
  // so no forwarding is needed
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[a_count[AW-1:0]] <= {load_index, elem_value};
    end
    rd_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[b_count[AW-1:0]] <= {load_index, elem_value};
    end
    rd_b <= mem_b[rd_addr_b];
  end

  // multiplier stage, one product per matching step
  always_ff @(posedge clk) begin
    prod <= mult;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VL_RESET;
    end else if (cfg_write) begin
      vector_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      a_count     <= '0;
      b_count     <= '0;
      load_error  <= 1'b0;
      ptr_a       <= '0;
      ptr_b       <= '0;
      prod_valid  <= 1'b0;
      acc         <= '0;
      sat         <= 1'b0;
      out_valid   <= 1'b0;
      dot_product <= '0;
      status      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      prod_valid <= match;
      acc        <= acc_next;
      sat        <= sat_next;
      unique case (state)
        S_IDLE: begin
          if (wr_a) begin
            a_count <= a_count + CW'(1);
          end
          if (wr_b) begin
            b_count <= b_count + CW'(1);
          end
          if (in_take && (command == CMD_LOAD_A || command == CMD_LOAD_B) && !wr_a && !wr_b) begin
            load_error <= 1'b1;
          end
          if (start) begin
            state <= S_MERGE;
            ptr_a <= '0;
            ptr_b <= '0;
          end
        end
        S_MERGE: begin
          ptr_a <= ptr_a_next;
          ptr_b <= ptr_b_next;
          if (!cont) begin
            // last product is folded in this cycle, acc_next is final
            if (out_free) begin
              dot_product <= acc_next;
              status      <= {load_error, sat_next};
              a_count     <= '0;
              b_count     <= '0;
              load_error  <= 1'b0;
              state       <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold the finished sum until the output register frees up
          if (out_free) begin
            dot_product <= acc_next;
            status      <= {load_error, sat_next};
            a_count     <= '0;
            b_count     <= '0;
            load_error  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // merge pointers stay within the loaded lists
  a_ptr_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (ptr_a <= a_count) && (ptr_b <= b_count))
    else $error("merge pointer past end of list");

  // list fill never passes the memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= MAX_COUNT) && (b_count <= MAX_COUNT))
    else $error("list count beyond depth");

  // a result only appears at the end of a compute
  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) != S_IDLE))
    else $error("result word without a compute");

  // leaving a compute empties both lists and the error flag
  a_lists_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && ($past(state) != S_IDLE)) |->
      (a_count == '0) && (b_count == '0) && !load_error)
    else $error("lists not emptied after result");

endmodule

### tb/dot_product_checker.sv
module dot_product_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [ssdp_pkg::VL_WIDTH-1:0]            cfg_data,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic [ssdp_pkg::CMD_WIDTH-1:0]           command,
  input  logic [ssdp_pkg::ELEM_INDEX_WIDTH-1:0]    elem_index,
  input  logic signed [ssdp_pkg::VALUE_WIDTH-1:0]  elem_value,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic signed [ssdp_pkg::ACC_WIDTH-1:0]    dot_product,
  input  logic [ssdp_pkg::STATUS_WIDTH-1:0]        status,
  output int                                       mismatches,
  output int                                       pending,
  output int                                       results_checked,
  output int                                       saturated_results,
  output int                                       error_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssdp_pkg::*;

  localparam int unsigned LIST_DEPTH = 1024;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] dot;
    logic [STATUS_WIDTH-1:0]     status;
  } dot_result_t;

  // shadow copy of both lists and the error flag
  logic [ELEM_INDEX_WIDTH-1:0]   a_idx [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] a_val [LIST_DEPTH];
  logic [ELEM_INDEX_WIDTH-1:0]   b_idx [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] b_val [LIST_DEPTH];
  int unsigned                   a_len = 0;
  int unsigned                   b_len = 0;
  bit                            load_err = 1'b0;
  logic [VL_WIDTH-1:0]           vec_len = VL_RESET;

  dot_result_t awaited_results [$];
  dot_result_t oldest;
  int          fail_total = 0;
  int          seen_total = 0;
  int          sat_total = 0;
  int          err_total = 0;

  initial begin
    mismatches = 0;
    pending = 0;
    results_checked = 0;
    saturated_results = 0;
    error_results = 0;
  end

  function automatic bit pair_fits(logic [ELEM_INDEX_WIDTH-1:0] idx, int unsigned len);
    return ({1'b0, idx} < vec_len) && (len < LIST_DEPTH);
  endfunction

  // two-pointer walk over the lists in load order, saturating on every add
  function automatic dot_result_t intersect_dot();
    int unsigned                 i;
    int unsigned                 j;
    logic signed [ACC_WIDTH-1:0] acc;
    logic signed [ACC_WIDTH-1:0] wa;
    logic signed [ACC_WIDTH-1:0] wb;
    logic signed [ACC_WIDTH-1:0] prod;
    logic [ACC_WIDTH:0]          sum;
    dot_result_t                 r;
    i = 0;
    j = 0;
    acc = '0;
    r.status = '0;
    while (i < a_len && j < b_len) begin
      if (a_idx[i] == b_idx[j]) begin
        wa = a_val[i];
        wb = b_val[j];
        prod = wa * wb;
        sum = {acc[ACC_WIDTH-1], acc} + {prod[ACC_WIDTH-1], prod};
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
          acc = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
          r.status[STATUS_SAT_BIT] = 1'b1;
        end else begin
          acc = sum[ACC_WIDTH-1:0];
        end
        i++;
        j++;
      end else if (a_idx[i] > b_idx[j]) begin
        j++;
      end else begin
        i++;
      end
    end
    r.dot = acc;
    r.status[STATUS_ERR_BIT] = load_err;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      a_len = 0;
      b_len = 0;
      load_err = 1'b0;
      vec_len = VL_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_write) begin
        vec_len = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with none expected, dot_product %h status %0d",
                   $time, dot_product, status);
          fail_total++;
        end else begin
          oldest = awaited_results.pop_front();
          seen_total++;
          if (oldest.status[STATUS_SAT_BIT]) sat_total++;
          if (oldest.status[STATUS_ERR_BIT]) err_total++;
          if (dot_product !== oldest.dot) begin
            $display("%0t: dot_product mismatch, expected %h, got %h",
                     $time, oldest.dot, dot_product);
            fail_total++;
          end
          if (status !== oldest.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, oldest.status, status);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (command)
          CMD_LOAD_A: begin
            if (pair_fits(elem_index, a_len)) begin
              a_idx[a_len] = elem_index;
              a_val[a_len] = elem_value;
              a_len++;
            end else begin
              load_err = 1'b1;
            end
          end
          CMD_LOAD_B: begin
            if (pair_fits(elem_index, b_len)) begin
              b_idx[b_len] = elem_index;
              b_val[b_len] = elem_value;
              b_len++;
            end else begin
              load_err = 1'b1;
            end
          end
          CMD_COMPUTE: begin
            awaited_results.push_back(intersect_dot());
            a_len = 0;
            b_len = 0;
            load_err = 1'b0;
          end
          default: ;
        endcase
      end
    end
    mismatches <= fail_total;
    pending <= awaited_results.size();
    results_checked <= seen_total;
    saturated_results <= sat_total;
    error_results <= err_total;
  end

endmodule

### tb/sparse_sparse_dot_product_test.sv
module sparse_sparse_dot_product_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssdp_pkg::*;

  // the one command code the package leaves unnamed: taken and ignored
  localparam logic [CMD_WIDTH-1:0] CMD_IGNORED = 2'd3;

  localparam int unsigned TIMEOUT_CYCLES  = 400000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned WORDS_PER_PHASE = 100;
  localparam int unsigned LIST_DEPTH      = 1024;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [VL_WIDTH-1:0]           cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [CMD_WIDTH-1:0]          command = CMD_LOAD_A;
  logic [ELEM_INDEX_WIDTH-1:0]   elem_index = '0;
  logic signed [VALUE_WIDTH-1:0] elem_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [ACC_WIDTH-1:0]   dot_product;
  logic [STATUS_WIDTH-1:0]       status;

  int mismatches;
  int pending;
  int results_checked;
  int saturated_results;
  int error_results;

  // percentages of cycles the sender sits idle and the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned phase_words = 0;
  int unsigned total_words = 0;
  int unsigned settings_run = 0;

  // vector_length for each phase: reset value, small, zero, one, above 65536,
  // odd mid size, largest 16-bit index space, and one random pick
  logic [VL_WIDTH-1:0] phase_length [NUM_PHASES] = '{
    17'h10000, 17'd16, 17'd0, 17'd1, 17'h1FFFF, 17'd300, 17'hFFFF, 17'd0
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sparse_sparse_dot_product dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .elem_index  (elem_index),
    .elem_value  (elem_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dot_product (dot_product),
    .status      (status)
  );

  dot_product_checker dot_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .command           (command),
    .elem_index        (elem_index),
    .elem_value        (elem_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .dot_product       (dot_product),
    .status            (status),
    .mismatches        (mismatches),
    .pending           (pending),
    .results_checked   (results_checked),
    .saturated_results (saturated_results),
    .error_results     (error_results)
  );

  // receiver side: random stall each cycle at the phase's rate
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one word and hold it until the block takes it; valid stays high
  // across back-to-back words so it never drops and rises in one step
  task automatic send_word(input logic [CMD_WIDTH-1:0] cmd,
                           input logic [ELEM_INDEX_WIDTH-1:0] idx,
                           input logic signed [VALUE_WIDTH-1:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    elem_index <= idx;
    elem_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CMD_IGNORED) begin
      phase_words++;
      total_words++;
    end
  endtask

  // let every pending result drain, then give the merge time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [VL_WIDTH-1:0] len);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // value mix: rails, zero, unit steps, small magnitudes, full random
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return $urandom_range(1) ? 32'sd1 : -32'sd1;
      4: return $signed(32'($urandom_range(32'h3FFFF))) - 32'sh2_0000;
      default: return $urandom;
    endcase
  endfunction

  // indices for broken sequences: anywhere, tiny range for repeats,
  // or right at the length boundary
  function automatic logic [ELEM_INDEX_WIDTH-1:0] stray_index(logic [VL_WIDTH-1:0] len);
    case ($urandom_range(3))
      0: return ELEM_INDEX_WIDTH'($urandom);
      1: return ELEM_INDEX_WIDTH'($urandom_range(7));
      2: return len[ELEM_INDEX_WIDTH-1:0];
      default: return len[ELEM_INDEX_WIDTH-1:0] - 1'b1;
    endcase
  endfunction

  // edge cases: empty compute, rails at both index ends, out-of-order list A,
  // ignored command, saturation that recovers, repeated indices
  task automatic run_directed();
    send_word(CMD_COMPUTE, 16'hFFFF, VAL_MIN);

    send_word(CMD_LOAD_A, 16'hFFFF, VAL_MAX);
    send_word(CMD_LOAD_A, 16'h0000, VAL_MIN);
    send_word(CMD_LOAD_B, 16'h0000, VAL_MIN);
    send_word(CMD_IGNORED, 16'h1234, 32'sh5A5A_A5A5);
    send_word(CMD_LOAD_B, 16'hFFFF, VAL_MAX);
    send_word(CMD_COMPUTE, 16'h0000, VAL_MAX);

    // three MIN*MIN products pin at the top, the last one pulls back down
    for (int k = 1; k <= 3; k++) begin
      send_word(CMD_LOAD_A, 16'(k), VAL_MIN);
      send_word(CMD_LOAD_B, 16'(k), VAL_MIN);
    end
    send_word(CMD_LOAD_A, 16'd4, VAL_MIN);
    send_word(CMD_LOAD_B, 16'd4, VAL_MAX);
    send_word(CMD_COMPUTE, 16'h8000, 32'sh0001_0000);

    // repeated index on both sides matches pairwise
    send_word(CMD_LOAD_A, 16'd7, 32'sh0003_0000);
    send_word(CMD_LOAD_A, 16'd7, -32'sh0002_8000);
    send_word(CMD_LOAD_B, 16'd7, 32'sh0001_0000);
    send_word(CMD_LOAD_B, 16'd7, 32'sh7FFF_0000);
    send_word(CMD_COMPUTE, 16'h5555, 32'shAAAA_AAAA);
  endtask

  // list A loaded one past capacity, list B sparse near the top so the
  // merge walks almost the whole of A
  task automatic fill_to_capacity();
    for (int k = 0; k <= LIST_DEPTH; k++) begin
      send_word(CMD_LOAD_A, 16'(k), pick_value());
    end
    send_word(CMD_LOAD_B, 16'd700, pick_value());
    send_word(CMD_LOAD_B, 16'd1023, pick_value());
    send_word(CMD_LOAD_B, 16'd1024, pick_value());
    send_word(CMD_COMPUTE, ELEM_INDEX_WIDTH'($urandom), $urandom);
  endtask

  // one pair of vectors then a compute; mostly ascending lists walked from
  // a shared start so many indices meet, the rest broken or stray
  task automatic run_vector_pair(input logic [VL_WIDTH-1:0] len);
    int unsigned                 lim;
    int unsigned                 n_a;
    int unsigned                 n_b;
    int unsigned                 sent_a;
    int unsigned                 sent_b;
    int unsigned                 cur_a;
    int unsigned                 cur_b;
    bit                          tidy;
    bit                          to_a;
    logic [ELEM_INDEX_WIDTH-1:0] idx;
    lim = (len == 0) ? 1 : ((len > 17'h10000) ? 32'h10000 : 32'(len));
    tidy = ($urandom_range(99) < 75);
    n_a = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    n_b = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    cur_a = $urandom_range(1) ? 0 : $urandom_range(lim - 1);
    cur_b = cur_a;
    sent_a = 0;
    sent_b = 0;
    while (sent_a < n_a || sent_b < n_b) begin
      to_a = (sent_a < n_a) && (sent_b >= n_b || $urandom_range(1) == 1);
      if (tidy) begin
        if (to_a) begin
          idx = cur_a[ELEM_INDEX_WIDTH-1:0];
          cur_a += $urandom_range(1, 3);
        end else begin
          idx = cur_b[ELEM_INDEX_WIDTH-1:0];
          cur_b += $urandom_range(1, 3);
        end
      end else begin
        if ($urandom_range(9) == 0) begin
          send_word(CMD_IGNORED, ELEM_INDEX_WIDTH'($urandom), $urandom);
        end
        idx = stray_index(len);
      end
      send_word(to_a ? CMD_LOAD_A : CMD_LOAD_B, idx, pick_value());
      if (to_a) sent_a++;
      else sent_b++;
    end
    send_word(CMD_COMPUTE, ELEM_INDEX_WIDTH'($urandom), $urandom);
  endtask

  initial begin
    phase_length[NUM_PHASES-1] = VL_WIDTH'($urandom_range(17'h1FFFF, 1));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_length(phase_length[p]);
      // idle mix rotates: none, sender gaps, receiver stalls, both light
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      phase_words = 0;
      if (p == 0) run_directed();
      if (phase_length[p] == 17'h1FFFF) fill_to_capacity();
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) run_vector_pair(phase_length[p]);
    end

    settle();
    $display("covered %0d words over %0d vector_length settings, including a list overfill",
             total_words, settings_run);
    $display("%0d results checked: %0d saturated, %0d flagged a load error",
             results_checked, saturated_results, error_results);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
